/* sv/ert_pkg.sv */
// Shared types and constants of the multi-channel echo ranging timer.
`timescale 1ns / 1ps

package ert_pkg;

    localparam int ECHO_W = 6;
    localparam int N_TIME = 6;
    localparam int TIME_W = 16;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [TIME_W-1:0] ERR_TIME = 16'hFFFF;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic [1:0] REG_TRIG_HIGH  = 2'd0;
    localparam logic [1:0] REG_START_TOUT = 2'd1;
    localparam logic [1:0] REG_DIST_TOUT  = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    localparam logic [7:0]  RST_TRIG_HIGH  = 8'd10;
    localparam logic [15:0] RST_START_TOUT = 16'd2600;
    localparam logic [15:0] RST_DIST_TOUT  = 16'd1750;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_MEAS
    } t_phase;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_WAIT,
        CS_HIGH,
        CS_DONE
    } t_stage;

    // Broadcast from the phase controller to every lane.
    typedef struct packed {
        logic clear;
        logic arm;
        logic step;
    } t_lane_cmd;

    typedef struct packed {
        logic pending;
        logic timeout;
    } t_lane_stat;

    typedef struct packed {
        logic [ECHO_W-1:0]             trig;
        logic                          busy;
        logic                          done;
        logic [1:0]                    status;
        logic [N_TIME-1:0][TIME_W-1:0] times;
    } t_result;

endpackage

/* sv/ert_lane.sv */
// One channel of the echo timer: waits for the echo to rise, then times its high phase.
`timescale 1ns / 1ps

module ert_lane import ert_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_lane_cmd         i_cmd,
    input  logic              i_active,
    input  logic              i_echo,
    input  logic [15:0]       i_start_tout,
    input  logic [15:0]       i_dist_tout,
    output t_lane_stat        o_stat,
    output logic [TIME_W-1:0] o_elapsed_next
);

    t_stage            r_stage, n_stage;
    logic [15:0]       r_ticks, n_ticks;
    logic [TIME_W-1:0] r_elapsed, n_elapsed;
    logic              w_timeout;
    logic [16:0]       w_inc;

    assign w_inc = {1'b0, r_ticks} + 17'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage   <= CS_IDLE;
            r_ticks   <= '0;
            r_elapsed <= ERR_TIME;
        end else begin
            r_stage   <= n_stage;
            r_ticks   <= n_ticks;
            r_elapsed <= n_elapsed;
        end
    end

    always_comb begin
        n_stage   = r_stage;
        n_ticks   = r_ticks;
        n_elapsed = r_elapsed;
        w_timeout = 1'b0;
        if (i_cmd.clear) begin
            n_stage   = CS_IDLE;
            n_ticks   = '0;
            n_elapsed = ERR_TIME;
        end else if (i_cmd.arm) begin
            n_stage = i_active ? CS_WAIT : CS_IDLE;
            n_ticks = '0;
        end else if (i_cmd.step) begin
            case (r_stage)
                CS_WAIT: begin
                    if (i_echo) begin
                        // The rising tick already counts as one high tick.
                        n_ticks = 16'd1;
                        if (17'd1 >= {1'b0, i_dist_tout}) begin
                            n_stage   = CS_DONE;
                            w_timeout = 1'b1;
                        end else begin
                            n_stage = CS_HIGH;
                        end
                    end else begin
                        n_ticks = w_inc[15:0];
                        if (w_inc >= {1'b0, i_start_tout} || w_inc[16]) begin
                            n_stage   = CS_DONE;
                            w_timeout = 1'b1;
                        end
                    end
                end
                CS_HIGH: begin
                    if (i_echo) begin
                        n_ticks = w_inc[15:0];
                        if (w_inc >= {1'b0, i_dist_tout}) begin
                            n_stage   = CS_DONE;
                            w_timeout = 1'b1;
                        end
                    end else begin
                        n_elapsed = r_ticks;
                        n_stage   = CS_DONE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stat.pending = (n_stage == CS_WAIT) || (n_stage == CS_HIGH);
    assign o_stat.timeout = w_timeout;
    assign o_elapsed_next = n_elapsed;

endmodule

/* sv/ert_ctrl.sv */
// Phase controller: decodes starts, runs the trigger phase and merges the lane results.
`timescale 1ns / 1ps

module ert_ctrl import ert_pkg::*; #(
    parameter int CHANNELS = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic                i_op,
    input  logic [2:0]          i_sel,
    input  logic [7:0]          i_trig_high,
    input  t_lane_stat          i_stat [CHANNELS],
    output t_lane_cmd           o_cmd,
    output logic [CHANNELS-1:0] o_mask,
    output logic [ECHO_W-1:0]   o_trig,
    output logic                o_busy,
    output logic                o_done,
    output logic [1:0]          o_status
);

    t_phase              r_phase, n_phase;
    logic [CHANNELS-1:0] r_mask, n_mask;
    logic [7:0]          r_pticks, n_pticks;
    logic                r_tout, n_tout;
    logic [CHANNELS-1:0] w_sel_mask;
    logic [CHANNELS-1:0] w_trig_src;
    logic [CHANNELS-1:0] w_pend_vec;
    logic [CHANNELS-1:0] w_tout_vec;
    logic                w_any_pend;
    logic                w_any_tout;
    logic [8:0]          w_pinc;

    // A code below CHANNELS picks one lane, a code equal to CHANNELS picks all.
    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            w_sel_mask[i] = ({1'b0, i_sel} == 4'(i)) || ({1'b0, i_sel} == 4'(CHANNELS));
            w_pend_vec[i] = i_stat[i].pending;
            w_tout_vec[i] = i_stat[i].timeout;
        end
    end

    assign w_any_pend = |w_pend_vec;
    assign w_any_tout = |w_tout_vec;
    assign w_pinc     = {1'b0, r_pticks} + 9'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_mask   <= '0;
            r_pticks <= '0;
            r_tout   <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_mask   <= n_mask;
            r_pticks <= n_pticks;
            r_tout   <= n_tout;
        end
    end

    // The lane command follows the transaction, phase and trigger count, never lane status.
    always_comb begin
        o_cmd = '0;
        if (i_fire) begin
            if (i_op == OP_START) begin
                o_cmd.clear = 1'b1;
            end else begin
                case (r_phase)
                    PH_TRIG: begin
                        o_cmd.arm = (w_pinc >= {1'b0, i_trig_high});
                    end
                    PH_MEAS: begin
                        o_cmd.step = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_mask     = r_mask;
        n_pticks   = r_pticks;
        n_tout     = r_tout;
        w_trig_src = '0;
        o_busy     = 1'b0;
        o_done     = 1'b0;
        o_status   = STATUS_OK;
        if (i_fire) begin
            if (i_op == OP_START) begin
                n_tout      = 1'b0;
                n_pticks    = '0;
                n_mask      = w_sel_mask;
                if (w_sel_mask == '0) begin
                    n_phase  = PH_IDLE;
                    o_done   = 1'b1;
                    o_status = STATUS_INVALID;
                end else begin
                    n_phase    = PH_TRIG;
                    w_trig_src = w_sel_mask;
                    o_busy     = 1'b1;
                end
            end else begin
                case (r_phase)
                    PH_TRIG: begin
                        o_busy = 1'b1;
                        if (w_pinc >= {1'b0, i_trig_high}) begin
                            n_phase   = PH_MEAS;
                            n_pticks  = '0;
                        end else begin
                            n_pticks   = w_pinc[7:0];
                            w_trig_src = r_mask;
                        end
                    end
                    PH_MEAS: begin
                        n_tout     = r_tout | w_any_tout;
                        if (w_any_pend) begin
                            o_busy = 1'b1;
                        end else begin
                            n_phase  = PH_IDLE;
                            o_done   = 1'b1;
                            o_status = (r_tout || w_any_tout) ? STATUS_TIMEOUT : STATUS_OK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_mask = r_mask;

    for (genvar g = 0; g < ECHO_W; g++) begin : g_trig
        if (g < CHANNELS) begin : g_on
            assign o_trig[g] = w_trig_src[g];
        end else begin : g_off
            assign o_trig[g] = 1'b0;
        end
    end

endmodule

/* sv/ert_outq.sv */
// Two-entry result buffer between the timer core and the result channel.
`timescale 1ns / 1ps

module ert_outq import ert_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_pop,
    output t_result o_data
);

    t_result    r_q [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       w_pop;

    assign w_pop   = i_pop && (r_count != 2'd0);
    assign o_space = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

endmodule

/* sv/multi_channel_echo_ranging_timer.sv */
// Multi-channel echo ranging timer: configuration registers, lanes, controller and result buffer.
// Throughput: one item per cycle while the result buffer has space; every lane updates in the
// same cycle the item is taken. Each result is registered in the buffer and offered in order.
// A two-entry result buffer lets input be taken while one finished result is still waiting.
// Reset (synchronous, active low) returns the registers to 10 / 2600 / 1750, all times to
// 65535, every lane and the phase to idle, and empties the result buffer.
`timescale 1ns / 1ps

module multi_channel_echo_ranging_timer import ert_pkg::*; #(
    parameter int CHANNELS = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_op,
    input  logic [2:0]         i_sensor_select,
    input  logic [ECHO_W-1:0]  i_echo_levels,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [ECHO_W-1:0]  o_trigger_levels,
    output logic               o_busy_res,
    output logic               o_done_res,
    output logic [1:0]         o_status,
    output logic [TIME_W-1:0]  o_time_ch0,
    output logic [TIME_W-1:0]  o_time_ch1,
    output logic [TIME_W-1:0]  o_time_ch2,
    output logic [TIME_W-1:0]  o_time_ch3,
    output logic [TIME_W-1:0]  o_time_ch4,
    output logic [TIME_W-1:0]  o_time_ch5
);

    logic [7:0]  r_trig_high;
    logic [15:0] r_start_tout;
    logic [15:0] r_dist_tout;
    logic        w_wr;
    logic [1:0]  w_reg_idx;

    logic                                  w_fire;
    t_lane_cmd                             w_cmd;
    logic [CHANNELS-1:0]                   w_mask;
    t_lane_stat                            w_stat [CHANNELS];
    logic [CHANNELS-1:0][TIME_W-1:0]       w_elapsed;
    logic [CHANNELS-1:0]                   w_echo;
    t_result                               w_res;
    t_result                               w_out;

    // Configuration port.
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_high  <= RST_TRIG_HIGH;
            r_start_tout <= RST_START_TOUT;
            r_dist_tout  <= RST_DIST_TOUT;
        end else if (w_wr) begin
            case (w_reg_idx)
                REG_TRIG_HIGH:  r_trig_high  <= pwdata[7:0];
                REG_START_TOUT: r_start_tout <= pwdata[15:0];
                REG_DIST_TOUT:  r_dist_tout  <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_TRIG_HIGH:  prdata = {24'd0, r_trig_high};
            REG_START_TOUT: prdata = {16'd0, r_start_tout};
            REG_DIST_TOUT:  prdata = {16'd0, r_dist_tout};
            default:        prdata = '0;
        endcase
    end

    assign w_fire = i_in_valid && o_in_ready;

    ert_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_op        (i_op),
        .i_sel       (i_sensor_select),
        .i_trig_high (r_trig_high),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_mask      (w_mask),
        .o_trig      (w_res.trig),
        .o_busy      (w_res.busy),
        .o_done      (w_res.done),
        .o_status    (w_res.status)
    );

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        // Lanes without an echo input always see the line low.
        if (g < ECHO_W) begin : g_echo
            assign w_echo[g] = i_echo_levels[g];
        end else begin : g_noecho
            assign w_echo[g] = 1'b0;
        end

        ert_lane u_lane (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_cmd          (w_cmd),
            .i_active       (w_mask[g]),
            .i_echo         (w_echo[g]),
            .i_start_tout   (r_start_tout),
            .i_dist_tout    (r_dist_tout),
            .o_stat         (w_stat[g]),
            .o_elapsed_next (w_elapsed[g])
        );
    end

    for (genvar k = 0; k < N_TIME; k++) begin : g_time
        if (k < CHANNELS) begin : g_on
            assign w_res.times[k] = w_elapsed[k];
        end else begin : g_off
            assign w_res.times[k] = ERR_TIME;
        end
    end

    ert_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fire),
        .i_data  (w_res),
        .o_space (o_in_ready),
        .o_valid (o_out_valid),
        .i_pop   (i_out_ready),
        .o_data  (w_out)
    );

    assign o_trigger_levels = w_out.trig;
    assign o_busy_res       = w_out.busy;
    assign o_done_res       = w_out.done;
    assign o_status         = w_out.status;
    assign o_time_ch0       = w_out.times[0];
    assign o_time_ch1       = w_out.times[1];
    assign o_time_ch2       = w_out.times[2];
    assign o_time_ch3       = w_out.times[3];
    assign o_time_ch4       = w_out.times[4];
    assign o_time_ch5       = w_out.times[5];

`ifndef SYNTHESIS
    a_busy_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |-> !(w_res.busy && w_res.done))
        else $error("busy and done raised on the same transaction");

    a_status_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_res.status != STATUS_OK) |-> w_res.done)
        else $error("nonzero status without done");

    a_invalid_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_res.status == STATUS_INVALID) |-> (w_res.trig == '0 && !w_res.busy))
        else $error("invalid selection drove triggers or stayed busy");

    a_trig_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_res.trig != '0) |-> w_res.busy)
        else $error("trigger lines high while not busy");
`endif

endmodule
